[rtl/sum_checked_frame_receiver_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sum-checked frame receiver
// Shared helpers for concurrent checks, clocked on rising edge, reset low.
// ----------------------------------------------------------------------------
`ifndef SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH
`define SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SCFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfr assertion failed");

// Check that cons holds in the cycle after ante.
`define SCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfr assertion failed");

`endif

[rtl/scfr_pkg.sv]
// ----------------------------------------------------------------------------
// scfr_pkg
// Types and constants shared by the sum-checked frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scfr_pkg;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_START_CHAR     = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_SEPARATOR_CHAR = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_END_CHAR       = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_CHECK_ENABLE   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [7:0] START_CHAR_RST     = 8'h24;  // '$'
  localparam logic [7:0] SEPARATOR_CHAR_RST = 8'h23;  // '#'
  localparam logic [7:0] END_CHAR_RST       = 8'h7C;  // '|'
  localparam logic       CHECK_ENABLE_RST   = 1'b1;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] separator_char;
    logic [7:0] end_char;
    logic       check_enable;
  } cfg_t;

  typedef struct packed {
    logic [31:0] good_frames;
    logic        frame_bad;
    logic        frame_ok;
  } result_t;

endpackage

[rtl/sum_checked_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// sum_checked_frame_receiver_top
// Additive-checksum ASCII frame receiver with a stream in, a stream out and
// a plain configuration write port.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte passes the input register and then the result
// register, with the frame state updated as it moves between the two.
// Throughput: one byte per cycle while m_axis_tready does not stall the output.
// Reset: asynchronous, active low; resets the frame state, clears the good count and
// both valid flags, and loads the character registers with '$', '#', '|'.
`timescale 1ns / 1ps

module sum_checked_frame_receiver_top
  import scfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [0] frame_ok, [1] frame_bad,
                                              // [33:2] good_frames, rest zero
);

  cfg_t       cfg_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    core_result;
  logic       out_free;
  logic       advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char     <= START_CHAR_RST;
      cfg_q.separator_char <= SEPARATOR_CHAR_RST;
      cfg_q.end_char       <= END_CHAR_RST;
      cfg_q.check_enable   <= CHECK_ENABLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_START_CHAR:     cfg_q.start_char     <= cfg_wdata_i;
        REG_SEPARATOR_CHAR: cfg_q.separator_char <= cfg_wdata_i;
        REG_END_CHAR:       cfg_q.end_char       <= cfg_wdata_i;
        REG_CHECK_ENABLE:   cfg_q.check_enable   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= core_result;
    end
  end

  scfr_frame_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .result_o  (core_result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - 34)'(0), out_q.good_frames,
                          out_q.frame_bad, out_q.frame_ok};

endmodule

[rtl/scfr_frame_core.sv]
// ----------------------------------------------------------------------------
// scfr_frame_core
// Frame state (sum, separator flag, decimal value, good count) and the
// per-byte update that yields one result for each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scfr_frame_core
  import scfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       step_i,
  input  logic [7:0] rx_byte_i,
  output result_t    result_o
);

  logic [31:0] running_sum_q, running_sum_d;
  logic        hash_seen_q, hash_seen_d;
  logic [31:0] digit_value_q, digit_value_d;
  logic        digits_open_q, digits_open_d;
  logic [31:0] valid_total_q, valid_total_d;

  logic        is_start, is_sep, is_end, is_digit;
  logic [35:0] digit_ext;
  logic [31:0] digit_next;
  logic        sum_match;

  assign is_start = (rx_byte_i == cfg_i.start_char);
  assign is_sep   = !is_start && (rx_byte_i == cfg_i.separator_char);
  assign is_end   = !is_start && !is_sep && (rx_byte_i == cfg_i.end_char);
  assign is_digit = (rx_byte_i >= ASCII_ZERO) && (rx_byte_i <= ASCII_NINE);

  // value * 10 + digit, saturate when it leaves 32 bits
  assign digit_ext = ({4'd0, digit_value_q} << 3) + ({4'd0, digit_value_q} << 1)
                   + {28'd0, rx_byte_i - ASCII_ZERO};
  assign digit_next = (digit_ext[35:32] != 4'd0) ? 32'hFFFF_FFFF : digit_ext[31:0];

  assign sum_match = (running_sum_q == digit_value_q);

  always_comb begin
    running_sum_d      = running_sum_q;
    hash_seen_d        = hash_seen_q;
    digit_value_d      = digit_value_q;
    digits_open_d      = digits_open_q;
    valid_total_d      = valid_total_q;
    result_o.frame_ok  = 1'b0;
    result_o.frame_bad = 1'b0;
    if (is_start) begin
      running_sum_d = '0;
      hash_seen_d   = 1'b0;
      digit_value_d = '0;
      digits_open_d = 1'b1;
    end else if (is_sep) begin
      running_sum_d = running_sum_q + {24'd0, rx_byte_i};
      hash_seen_d   = 1'b1;
      digit_value_d = '0;
      digits_open_d = 1'b1;
    end else if (is_end) begin
      if (hash_seen_q) begin
        if (!cfg_i.check_enable || sum_match) begin
          result_o.frame_ok = 1'b1;
          valid_total_d     = valid_total_q + 32'd1;
        end else begin
          result_o.frame_bad = 1'b1;
        end
      end
    end else begin
      if (!hash_seen_q) begin
        running_sum_d = running_sum_q + {24'd0, rx_byte_i};
      end
      if (digits_open_q) begin
        if (is_digit) begin
          digit_value_d = digit_next;
        end else begin
          digits_open_d = 1'b0;
        end
      end
    end
    result_o.good_frames = valid_total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= '0;
      hash_seen_q   <= 1'b0;
      digit_value_q <= '0;
      digits_open_q <= 1'b1;
      valid_total_q <= '0;
    end else if (step_i) begin
      running_sum_q <= running_sum_d;
      hash_seen_q   <= hash_seen_d;
      digit_value_q <= digit_value_d;
      digits_open_q <= digits_open_d;
      valid_total_q <= valid_total_d;
    end
  end

endmodule

[rtl/scfr_checker.sv]
// ----------------------------------------------------------------------------
// scfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sum_checked_frame_receiver_top_macros.svh"

module scfr_checker
  import scfr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [31:0] last_good_q, last_good_d;
  logic        out_take;

  assign out_take    = m_axis_tvalid && m_axis_tready;
  assign last_good_d = out_take ? m_axis_tdata[33:2] : last_good_q;

  // track the good count of the last delivered item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_good_q <= '0;
    end else begin
      last_good_q <= last_good_d;
    end
  end

  `SCFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SCFR_ASSERT_SAME(a_ok_bad_excl, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))
  `SCFR_ASSERT_SAME(a_count_step, clk_i, rst_ni, out_take, m_axis_tdata[33:2] == last_good_q + {31'd0, m_axis_tdata[0]})

endmodule

bind sum_checked_frame_receiver_top scfr_checker u_scfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[sim/tb_sum_checked_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// Testbench for sum_checked_frame_receiver_top
// Streams ASCII frames through the receiver under several character settings,
// with random source gaps and sink back-pressure. Predicts the checksum verdict
// and good-frame count of every byte and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sum_checked_frame_receiver_top;
  import scfr_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [0] frame_ok, [1] frame_bad,
                                            // [33:2] good_frames, rest zero

  // Character settings as the receiver should hold them
  logic [7:0]  cfg_start = START_CHAR_RST;
  logic [7:0]  cfg_sep   = SEPARATOR_CHAR_RST;
  logic [7:0]  cfg_end   = END_CHAR_RST;
  logic        cfg_check = CHECK_ENABLE_RST;

  // Frame state of the predictor
  logic [31:0] frame_sum    = '0;
  logic        sep_seen     = 1'b0;
  logic [31:0] cksum_value  = '0;
  logic        digits_live  = 1'b1;
  logic [31:0] good_count   = '0;

  result_t     verdict_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_reqs     = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned ok_seen      = 0;
  int unsigned bad_seen     = 0;
  int unsigned settings_run = 1;
  int unsigned error_count  = 0;

  sum_checked_frame_receiver_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Verdict and good-frame count that one received byte produces
  function automatic result_t judge_byte(input logic [7:0] b);
    result_t     r;
    logic [63:0] grown;
    r = '0;
    if (b == cfg_start) begin
      frame_sum   = '0;
      sep_seen    = 1'b0;
      cksum_value = '0;
      digits_live = 1'b1;
    end else if (b == cfg_sep) begin
      frame_sum   = frame_sum + {24'd0, b};
      sep_seen    = 1'b1;
      cksum_value = '0;
      digits_live = 1'b1;
    end else if (b == cfg_end) begin
      if (sep_seen) begin
        if (!cfg_check || frame_sum == cksum_value) begin
          r.frame_ok = 1'b1;
          good_count = good_count + 32'd1;
        end else begin
          r.frame_bad = 1'b1;
        end
      end
    end else begin
      if (!sep_seen) frame_sum = frame_sum + {24'd0, b};
      if (digits_live) begin
        if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
          grown = {32'd0, cksum_value};
          grown = grown * 64'd10 + {56'd0, b - ASCII_ZERO};
          cksum_value = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
        end else begin
          digits_live = 1'b0;
        end
      end
    end
    r.good_frames = good_count;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    error_count++;
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  // Sink side: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_reqs != hold_served) begin
      hold_served   <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        flag_mismatch("result with no byte pending", m_axis_tdata[31:0], '0);
      end else begin
        want = verdict_q.pop_front();
        got  = m_axis_tdata[$bits(result_t)-1:0];
        if (got.frame_ok !== want.frame_ok)
          flag_mismatch("frame_ok", 32'(got.frame_ok), 32'(want.frame_ok));
        if (got.frame_bad !== want.frame_bad)
          flag_mismatch("frame_bad", 32'(got.frame_bad), 32'(want.frame_bad));
        if (got.good_frames !== want.good_frames)
          flag_mismatch("good_frames", got.good_frames, want.good_frames);
        if (m_axis_tdata[OutDataW-1:$bits(result_t)] !== '0)
          flag_mismatch("padding", 32'(m_axis_tdata[OutDataW-1:$bits(result_t)]), '0);
        if (got.frame_ok === 1'b1) ok_seen++;
        if (got.frame_bad === 1'b1) bad_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results pending",
                 quiet_cycles, verdict_q.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= InDataW'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    verdict_q.push_back(judge_byte(b));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // Drop valid and hold until every pending result has come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_chars(input logic [7:0] st, input logic [7:0] sp,
                           input logic [7:0] en, input logic chk);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_START_CHAR;
    cfg_wdata_i <= st;
    @(posedge clk_i);
    cfg_addr_i  <= REG_SEPARATOR_CHAR;
    cfg_wdata_i <= sp;
    @(posedge clk_i);
    cfg_addr_i  <= REG_END_CHAR;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    // upper bits are don't-care for the enable
    cfg_addr_i  <= REG_CHECK_ENABLE;
    cfg_wdata_i <= {7'($urandom), chk};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_start = st;
    cfg_sep   = sp;
    cfg_end   = en;
    cfg_check = chk;
    settings_run++;
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
    send_idle_pct = src_pct;
    stall_pct     = sink_pct;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == cfg_start || b == cfg_sep || b == cfg_end) b = 8'($urandom_range(255));
    return b;
  endfunction

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic send_frame();
    int unsigned kind;
    int unsigned n;
    logic [31:0] claim;
    logic [7:0]  txt[$];
    kind = $urandom_range(99);
    if (kind >= 88) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(5))
          0:       send_byte(cfg_start);
          1:       send_byte(cfg_sep);
          2:       send_byte(cfg_end);
          default: send_byte(8'($urandom_range(255)));
        endcase
      end
    end else begin
      send_byte(cfg_start);
      n = $urandom_range(0, 10);
      repeat (n) send_byte(plain_byte());
      if (kind < 80) begin
        send_byte(cfg_sep);
        if (kind >= 70) begin
          repeat ($urandom_range(0, 3)) send_byte(plain_byte());
          send_byte(cfg_sep);
        end
        claim = frame_sum;
        case ($urandom_range(9))
          0:       claim = claim + 1;
          1:       claim = $urandom;
          default: ;
        endcase
        do begin
          txt.push_front(8'(ASCII_ZERO + claim % 10));
          claim = claim / 10;
        end while (claim != 0);
        foreach (txt[k]) send_byte(txt[k]);
        // now and then add a stray byte after the number; a non-digit closes it early
        if ($urandom_range(9) == 0) send_byte(plain_byte());
      end
      send_byte(cfg_end);
      if ($urandom_range(4) == 0) send_byte(cfg_end);
    end
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned target;
    target = items_sent + n_items;
    while (items_sent < target) send_frame();
  endtask

  task automatic test_directed_defaults();
    set_idling(0, 0);
    // extreme data bytes, sum 0 + 255 + '#' = 290
    send_byte(START_CHAR_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SEPARATOR_CHAR_RST);
    send_text("290");
    send_byte(END_CHAR_RST);
    // repeated end is judged again on the same sum
    send_byte(END_CHAR_RST);
    // digit after end extends the number
    send_text("5");
    send_byte(END_CHAR_RST);
    // end without separator
    send_byte(START_CHAR_RST);
    send_byte(END_CHAR_RST);
    // empty checksum, then saturating digits
    send_byte(START_CHAR_RST);
    send_byte(SEPARATOR_CHAR_RST);
    send_byte(END_CHAR_RST);
    send_text("9999999999");
    send_byte(END_CHAR_RST);
  endtask

  task automatic test_no_idling();
    set_idling(0, 0);
    run_traffic(350);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_reqs <= hold_reqs + 1;
    run_traffic(120);
    // let everything drain before offering more
    wait_idle();
    run_traffic(60);
  endtask

  task automatic test_char_extremes();
    set_chars(8'h00, 8'hFF, 8'h80, 1'b1);
    set_idling(82, 0);
    run_traffic(200);
    set_chars(8'hFF, 8'h00, 8'h01, 1'b0);
    set_idling(0, 82);
    run_traffic(200);
  endtask

  task automatic test_check_disabled();
    set_chars(START_CHAR_RST, SEPARATOR_CHAR_RST, END_CHAR_RST, 1'b0);
    set_idling(29, 29);
    run_traffic(200);
  endtask

  task automatic test_coinciding_chars();
    set_idling(29, 29);
    // start wins over separator
    set_chars(8'h24, 8'h24, 8'h7C, 1'b1);
    run_traffic(60);
    // separator wins over end
    set_chars(8'h24, 8'h7C, 8'h7C, 1'b0);
    run_traffic(60);
    // start wins over end
    set_chars(8'h7C, 8'h23, 8'h7C, 1'b1);
    run_traffic(40);
  endtask

  task automatic test_random_settings();
    logic [7:0] st;
    logic [7:0] sp;
    logic [7:0] en;
    for (int r = 0; r < 4; r++) begin
      st = 8'($urandom_range(255));
      sp = 8'($urandom_range(255));
      en = 8'($urandom_range(255));
      set_chars(st, sp, en, ($urandom_range(3) != 0));
      if (r == 3) set_idling(0, 82);
      else set_idling(29, 29);
      run_traffic(120);
    end
    set_chars(START_CHAR_RST, SEPARATOR_CHAR_RST, END_CHAR_RST, 1'b1);
    set_idling(29, 29);
    run_traffic(100);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_no_idling();
    test_backpressure();
    test_char_extremes();
    test_check_disabled();
    test_coinciding_chars();
    test_random_settings();

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (verdict_q.size() != 0)
      flag_mismatch("results never delivered", verdict_q.size(), 0);

    $display("covered %0d bytes under %0d character settings, %0d results checked",
             items_sent, settings_run, results_seen);
    $display("frames accepted %0d, rejected on checksum %0d, mismatches %0d",
             ok_seen, bad_seen, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sum_checked_frame_receiver_top.f]
+incdir+rtl
rtl/scfr_pkg.sv
rtl/scfr_frame_core.sv
rtl/sum_checked_frame_receiver_top.sv
rtl/scfr_checker.sv
sim/tb_sum_checked_frame_receiver_top.sv
